FILE: hw/rtl/memb_pkg.sv
// Shared types, constants and saturation helper for the membrane element kernel.
package memb_pkg;

  localparam int VAL_W     = 48;
  localparam int UVAL_W    = 47;
  localparam int NODE_W    = 16;
  localparam int DOF_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [VAL_W-1:0] MAX48    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN48    = 48'sh8000_0000_0000;
  localparam logic signed [VAL_W-1:0] TWO_PI_Q = 48'sh0006_487E_D511;

  localparam logic [UVAL_W-1:0] PERM_RESET  = 47'h1_0000_0000;
  localparam logic [UVAL_W-1:0] THICK_RESET = 47'h1_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_PERMITTIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS    = 2'd2;

  typedef enum logic [2:0] {
    KIND_FORCE,
    KIND_COL0,
    KIND_COL1,
    KIND_COL2,
    KIND_COL3
  } kind_t;

  typedef struct packed {
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [VAL_W-1:0]  xa;
    logic signed [VAL_W-1:0]  ya;
    logic signed [VAL_W-1:0]  xb;
    logic signed [VAL_W-1:0]  yb;
    logic [UVAL_W-1:0]        ref_length;
    logic [UVAL_W-1:0]        start_radius_a;
    logic [UVAL_W-1:0]        start_radius_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               result_kind;
    logic [DOF_W-1:0]         dof_base_a;
    logic [DOF_W-1:0]         dof_base_b;
    logic signed [VAL_W-1:0]  value_0;
    logic signed [VAL_W-1:0]  value_1;
    logic signed [VAL_W-1:0]  value_2;
    logic signed [VAL_W-1:0]  value_3;
    logic                     last;
  } out_item_t;

  // classified element as queued between front and engine
  typedef struct packed {
    logic [DOF_W-1:0]         dof_a;
    logic [DOF_W-1:0]         dof_b;
    logic signed [VAL_W-1:0]  s;
    logic signed [VAL_W-1:0]  d;
    logic signed [VAL_W-1:0]  e;
    logic [UVAL_W-1:0]        lref;
    logic [UVAL_W-1:0]        r;
  } elem_t;

  // per-element products handed to the emitter
  typedef struct packed {
    logic [DOF_W-1:0]         dof_a;
    logic [DOF_W-1:0]         dof_b;
    logic signed [VAL_W-1:0]  f0;
    logic signed [VAL_W-1:0]  f1;
    logic signed [VAL_W-1:0]  f2n;
    logic signed [VAL_W-1:0]  a;
    logic signed [VAL_W-1:0]  b;
    logic signed [VAL_W-1:0]  c;
    logic signed [VAL_W-1:0]  g;
  } bank_t;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W-1:0] res;
    if (v > (VAL_W+2)'(MAX48)) res = MAX48;
    else if (v < (VAL_W+2)'(MIN48)) res = MIN48;
    else res = v[VAL_W-1:0];
    return res;
  endfunction

endpackage

FILE: hw/rtl/memb_front.sv
// Input stage: accepts elements, forms sums/differences, mean radius and dof bases, queues them.
module memb_front #(
  parameter int NODE_INDEX_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  memb_pkg::in_item_t in_data,
  output logic              q_valid,
  output memb_pkg::elem_t   q_elem,
  input  logic              q_pop
);
  import memb_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam logic [NODE_W-1:0] NODE_MASK = (NODE_INDEX_BITS >= NODE_W) ?
    {NODE_W{1'b1}} : NODE_W'((32'd1 << NODE_INDEX_BITS) - 32'd1);

  elem_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push;
  elem_t             elem_in;

  assign in_ready = (cnt_r != CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_elem   = mem_r[rd_ptr_r];

  always_comb begin
    elem_in.dof_a = {in_data.node_a & NODE_MASK, 1'b0};
    elem_in.dof_b = {in_data.node_b & NODE_MASK, 1'b0};
    elem_in.s     = sat48((VAL_W+2)'($signed(in_data.xa)) + (VAL_W+2)'($signed(in_data.xb)));
    elem_in.d     = sat48((VAL_W+2)'($signed(in_data.xb)) - (VAL_W+2)'($signed(in_data.xa)));
    elem_in.e     = sat48((VAL_W+2)'($signed(in_data.yb)) - (VAL_W+2)'($signed(in_data.ya)));
    elem_in.lref  = in_data.ref_length;
    elem_in.r     = UVAL_W'(((UVAL_W+1)'(in_data.start_radius_a) +
                             (UVAL_W+1)'(in_data.start_radius_b)) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      if (q_pop) rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      cnt_r <= CNT_W'(cnt_r + CNT_W'(push) - CNT_W'(q_pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= elem_in;
  end

endmodule

FILE: hw/rtl/memb_mulq.sv
// Q16.32 multiplier: two 48x24 partial products summed with rounding, then saturation.
module memb_mulq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [memb_pkg::VAL_W-1:0]  op_a,
  input  logic signed [memb_pkg::VAL_W-1:0]  op_b,
  output logic                               done,
  output logic signed [memb_pkg::VAL_W-1:0]  res
);
  import memb_pkg::*;

  logic [VAL_W-1:0]         ma_r, mb_r;
  logic                     neg_r;
  logic [71:0]              plo_r;
  logic [71:0]              phi;
  logic [95:0]              acc_r;
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [VAL_W-1:0]  res_r;
  logic                     ovf;
  logic [VAL_W-1:0]         mag;

  assign phi  = ma_r * mb_r[47:24];
  assign ovf  = |acc_r[95:79];
  assign mag  = {1'b0, acc_r[78:32]};
  assign done = v4_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= op_a[VAL_W-1] ? VAL_W'(~op_a + 48'd1) : op_a;
      mb_r  <= op_b[VAL_W-1] ? VAL_W'(~op_b + 48'd1) : op_b;
      neg_r <= op_a[VAL_W-1] ^ op_b[VAL_W-1];
    end
    plo_r <= ma_r * mb_r[23:0];
    acc_r <= {24'd0, plo_r} + {phi, 24'd0} + 96'h8000_0000;
    if (ovf) res_r <= neg_r ? MIN48 : MAX48;
    else     res_r <= neg_r ? VAL_W'(~mag + 48'd1) : mag;
  end

endmodule

FILE: hw/rtl/memb_div.sv
// Restoring divider, one quotient bit per cycle, Q16.32 with round-half-up and saturation.
module memb_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [memb_pkg::VAL_W-1:0]         num,
  input  logic [memb_pkg::VAL_W-1:0]         den,
  output logic                               done,
  output logic signed [memb_pkg::VAL_W-1:0]  quo
);
  import memb_pkg::*;

  localparam int DVD_W = VAL_W + 32;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_r, quo_r;
  logic [VAL_W-1:0]  den_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [VAL_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign done   = done_r;
  assign quo    = (den_r == '0 || (|quo_r[DVD_W-1:VAL_W-1])) ? MAX48 :
                  {1'b0, quo_r[VAL_W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, 32'd0} + {32'd0, 1'b0, den[VAL_W-1:1]};
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? VAL_W'(rem_sh - {1'b0, den_r}) : rem_sh[VAL_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/memb_engine.sv
// Compute engine: sequences the shared multiplier and divider over one element.
module memb_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [memb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [memb_pkg::VAL_W-1:0]      cfg_data,
  input  logic                            q_valid,
  input  memb_pkg::elem_t                 q_elem,
  output logic                            q_pop,
  input  logic                            bank_ready,
  output logic                            bank_load,
  output memb_pkg::bank_t                 bank
);
  import memb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_HOLD
  } state_t;

  typedef enum logic [4:0] {
    ST_LR, ST_DEN, ST_TP, ST_VV, ST_NUM, ST_S2, ST_DS, ST_SE, ST_DD, ST_EE,
    ST_S2E, ST_F1, ST_A, ST_B, ST_C, ST_G, ST_SM, ST_F0, ST_SP, ST_F2
  } step_t;

  state_t  state_r;
  step_t   step_r;

  logic [UVAL_W-1:0]        perm_r, thick_r;
  logic signed [VAL_W-1:0]  volt_r;

  elem_t                    elem_r;
  logic signed [VAL_W-1:0]  tmp1_r, tmp2_r, den_r, num_r, k_r, h_r, qk_r;
  logic signed [VAL_W-1:0]  s2_r, ds_r, se_r, q_r, f0_r, f1_r, f2n_r, a_r, b_r, c_r, g_r;

  logic signed [VAL_W-1:0]  op_a, op_b, mul_res, div_quo;
  logic                     mul_start, mul_done, div_start, div_done;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign bank_load = (state_r == S_HOLD) && bank_ready;
  assign mul_start = (state_r == S_MUL_GO);
  assign div_start = (state_r == S_DIV_GO);

  memb_mulq u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  memb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r  <= PERM_RESET;
      volt_r  <= '0;
      thick_r <= THICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERMITTIVITY: perm_r  <= cfg_data[UVAL_W-1:0];
        REG_VOLTAGE:      volt_r  <= cfg_data;
        REG_THICKNESS:    thick_r <= cfg_data[UVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      ST_LR:  begin op_a = {1'b0, elem_r.lref}; op_b = {1'b0, elem_r.r}; end
      ST_DEN: begin op_a = tmp1_r;   op_b = {1'b0, thick_r}; end
      ST_TP:  begin op_a = TWO_PI_Q; op_b = {1'b0, perm_r}; end
      ST_VV:  begin op_a = volt_r;   op_b = volt_r; end
      ST_NUM: begin op_a = tmp1_r;   op_b = tmp2_r; end
      ST_S2:  begin op_a = elem_r.s; op_b = elem_r.s; end
      ST_DS:  begin op_a = elem_r.d; op_b = elem_r.s; end
      ST_SE:  begin op_a = elem_r.s; op_b = elem_r.e; end
      ST_DD:  begin op_a = elem_r.d; op_b = elem_r.d; end
      ST_EE:  begin op_a = elem_r.e; op_b = elem_r.e; end
      ST_S2E: begin op_a = s2_r;     op_b = elem_r.e; end
      ST_F1:  begin op_a = qk_r;     op_b = tmp1_r; end
      ST_A:   begin op_a = qk_r;     op_b = s2_r; end
      ST_B:   begin op_a = h_r;      op_b = se_r; end
      ST_C:   begin op_a = qk_r;     op_b = q_r; end
      ST_G:   begin op_a = k_r;      op_b = ds_r; end
      ST_SM:  begin
        op_a = elem_r.s;
        op_b = sat48((VAL_W+2)'(ds_r) - (VAL_W+2)'(q_r));
      end
      ST_F0:  begin op_a = qk_r;     op_b = tmp1_r; end
      ST_SP:  begin
        op_a = elem_r.s;
        op_b = sat48((VAL_W+2)'(ds_r) + (VAL_W+2)'(q_r));
      end
      ST_F2:  begin op_a = qk_r;     op_b = tmp1_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_LR;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_MUL_GO;
            step_r  <= ST_LR;
          end
        end
        S_MUL_GO: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (step_r == ST_F2) begin
              state_r <= S_HOLD;
            end else begin
              step_r  <= step_t'(step_r + 5'd1);
              state_r <= (step_r == ST_NUM) ? S_DIV_GO : S_MUL_GO;
            end
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) state_r <= S_MUL_GO;
        end
        S_HOLD: begin
          if (bank_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) elem_r <= q_elem;
    if (div_done) begin
      k_r  <= div_quo;
      h_r  <= VAL_W'(((VAL_W+1)'(div_quo) + 49'd1) >> 1);
      qk_r <= VAL_W'(((VAL_W+1)'(div_quo) + 49'd2) >> 2);
    end
    if (mul_done) begin
      case (step_r)
        ST_LR:  tmp1_r <= mul_res;
        ST_DEN: den_r  <= mul_res;
        ST_TP:  tmp1_r <= mul_res;
        ST_VV:  tmp2_r <= mul_res;
        ST_NUM: num_r  <= mul_res;
        ST_S2:  s2_r   <= mul_res;
        ST_DS:  ds_r   <= mul_res;
        ST_SE:  se_r   <= mul_res;
        ST_DD:  tmp1_r <= mul_res;
        ST_EE:  q_r    <= sat48((VAL_W+2)'(tmp1_r) + (VAL_W+2)'(mul_res));
        ST_S2E: tmp1_r <= mul_res;
        ST_F1:  f1_r   <= mul_res;
        ST_A:   a_r    <= mul_res;
        ST_B:   b_r    <= mul_res;
        ST_C:   c_r    <= mul_res;
        ST_G:   g_r    <= mul_res;
        ST_SM:  tmp1_r <= mul_res;
        ST_F0:  f0_r   <= mul_res;
        ST_SP:  tmp1_r <= mul_res;
        ST_F2:  f2n_r  <= mul_res;
        default: ;
      endcase
    end
  end

  always_comb begin
    bank.dof_a = elem_r.dof_a;
    bank.dof_b = elem_r.dof_b;
    bank.f0    = f0_r;
    bank.f1    = f1_r;
    bank.f2n   = f2n_r;
    bank.a     = a_r;
    bank.b     = b_r;
    bank.c     = c_r;
    bank.g     = g_r;
  end

endmodule

FILE: hw/rtl/memb_emit.sv
// Result bank and output register: emits the force beat and four Jacobian column beats.
module memb_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bank_load,
  input  memb_pkg::bank_t     bank,
  output logic                bank_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output memb_pkg::out_item_t out_data
);
  import memb_pkg::*;

  bank_t      bank_r;
  logic       bank_vld_r;
  kind_t      beat_r, beat_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r, beat_data;
  logic       load_out;
  logic signed [VAL_W+1:0] f0_x, f1_x, f2n_x, a_x, b_x, c_x, g_x;

  assign bank_ready = !bank_vld_r;
  assign load_out   = bank_vld_r && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign f0_x  = (VAL_W+2)'($signed(bank_r.f0));
  assign f1_x  = (VAL_W+2)'($signed(bank_r.f1));
  assign f2n_x = (VAL_W+2)'($signed(bank_r.f2n));
  assign a_x   = (VAL_W+2)'($signed(bank_r.a));
  assign b_x   = (VAL_W+2)'($signed(bank_r.b));
  assign c_x   = (VAL_W+2)'($signed(bank_r.c));
  assign g_x   = (VAL_W+2)'($signed(bank_r.g));

  always_comb begin
    beat_data.result_kind = beat_r;
    beat_data.dof_base_a  = bank_r.dof_a;
    beat_data.dof_base_b  = bank_r.dof_b;
    beat_data.last        = (beat_r == KIND_COL3);
    beat_nxt              = KIND_FORCE;
    beat_data.value_0     = '0;
    beat_data.value_1     = '0;
    beat_data.value_2     = '0;
    beat_data.value_3     = '0;
    case (beat_r)
      KIND_FORCE: begin
        beat_nxt          = KIND_COL0;
        beat_data.value_0 = sat48(f0_x);
        beat_data.value_1 = sat48(f1_x);
        beat_data.value_2 = sat48(-f2n_x);
        beat_data.value_3 = sat48(-f1_x);
      end
      KIND_COL0: begin
        beat_nxt          = KIND_COL1;
        beat_data.value_0 = sat48(g_x - a_x - c_x);
        beat_data.value_1 = sat48(b_x);
        beat_data.value_2 = sat48(a_x - c_x);
        beat_data.value_3 = sat48(-b_x);
      end
      KIND_COL1: begin
        beat_nxt          = KIND_COL2;
        beat_data.value_0 = sat48(b_x);
        beat_data.value_1 = sat48(-a_x);
        beat_data.value_2 = sat48(b_x);
        beat_data.value_3 = sat48(a_x);
      end
      KIND_COL2: begin
        beat_nxt          = KIND_COL3;
        beat_data.value_0 = sat48(a_x - c_x);
        beat_data.value_1 = sat48(b_x);
        beat_data.value_2 = sat48(-g_x - a_x - c_x);
        beat_data.value_3 = sat48(-b_x);
      end
      KIND_COL3: begin
        beat_nxt          = KIND_FORCE;
        beat_data.value_0 = sat48(-b_x);
        beat_data.value_1 = sat48(a_x);
        beat_data.value_2 = sat48(-b_x);
        beat_data.value_3 = sat48(-a_x);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      beat_r      <= KIND_FORCE;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        beat_r      <= beat_nxt;
        if (beat_r == KIND_COL3) bank_vld_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (bank_load) bank_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bank_load) bank_r <= bank;
    if (load_out) out_data_r <= beat_data;
  end

endmodule

FILE: hw/rtl/membrane_electrostatic_element_kernel_top.sv
// Top level of the membrane electrostatic element kernel.
// Each accepted element yields five beats: the force vector, then Jacobian columns 0 to 3
// (last set on column 3). For each element the compute engine pops the queue, runs twenty
// Q16.32 multiplies on one shared multiplier built from two 48x24-bit partial products and
// a bit-serial divide of 80 quotient bits for the load coefficient, then hands off the
// results. A two-entry input queue takes new elements while the engine works, and the five
// result beats drain from an output bank while the next element computes; the engine takes
// one element at a time, and its handoff waits until the bank is free. Configuration is
// written through cfg_we/cfg_index/cfg_data; write it only while the block is idle, as the
// block itself does not enforce this.
module membrane_electrostatic_element_kernel_top #(
  parameter int NODE_INDEX_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  memb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output memb_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [memb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [memb_pkg::VAL_W-1:0]      cfg_data
);
  import memb_pkg::*;

  logic   q_valid, q_pop, bank_ready, bank_load;
  elem_t  q_elem;
  bank_t  bank;

  memb_front #(
    .NODE_INDEX_BITS (NODE_INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_elem   (q_elem),
    .q_pop    (q_pop)
  );

  memb_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_elem     (q_elem),
    .q_pop      (q_pop),
    .bank_ready (bank_ready),
    .bank_load  (bank_load),
    .bank       (bank)
  );

  memb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .bank_load  (bank_load),
    .bank       (bank),
    .bank_ready (bank_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: hw/rtl/memb_checker.sv
// Port-level assertions for the kernel top, attached by bind.
module memb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input memb_pkg::out_item_t out_data
);
  import memb_pkg::*;

  a_last_on_col3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.result_kind == KIND_COL3)
    else $error("last beat is not Jacobian column 3");

  a_col3_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_COL3 |-> out_data.last)
    else $error("column 3 beat without last");

  a_element_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside an element's beats");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_dof_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.dof_base_a[0] && !out_data.dof_base_b[0])
    else $error("odd dof base");

endmodule

bind membrane_electrostatic_element_kernel_top memb_checker u_memb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
